@@ rtl/core/ecal_pkg.sv @@
// Shared types, constants and tables for the epoch seconds to calendar converter
package ecal_pkg;

  // Field widths of the internal beats
  localparam int DOE_W = 18;  // day of 400-year era, 0..146096
  localparam int SOD_W = 17;  // second of day, 0..86399

  // Calendar constants
  localparam logic [SOD_W-1:0] DAY_LAST_SEC = 17'd86399;
  localparam int               DAY_ODD      = 675;     // 86400 = 675 * 128
  localparam int               DAY_LO_SHIFT = 7;
  localparam int               MARCH_SHIFT  = 719468;  // days from 0000-03-01 to 1970-01-01
  localparam int               ERA_DAYS     = 146097;
  localparam logic [DOE_W-1:0] ERA_LAST_DOE = 18'd146096;
  localparam int               UNIT_60      = 60;
  localparam int               YEAR_DAYS    = 365;
  localparam int               ERA_YEARS    = 400;
  localparam int               YEAR_BASE    = 1900;
  localparam int               WEEK_DAYS    = 7;
  localparam int               WDAY_SHIFT   = 3;       // doe 0 of any era is a Wednesday
  localparam logic [3:0]       MP_JAN       = 4'd10;   // March-based month of January

  // Latency from start to strobe
  localparam int PIPE_LATENCY = 14;

  // Exact reciprocals: floor(x / d) = (x * ceil(2^(n+s) / d)) >> (n+s), x < 2^n, 2^s >= d
  localparam logic [22:0] RCP_T675   = 23'(((64'd1 << 32) + 64'd674) / 64'd675);
  localparam logic [17:0] RCP_SOD60  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
  localparam logic [11:0] RCP_MIN60  = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
  localparam logic [18:0] RCP_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RCP_36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RCP_365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [18:0] RCP_WEEK   = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
  localparam logic [9:0]  RCP_100    = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] RCP_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // Time of day
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] minute;
    logic [4:0] hour;
  } tod_t;

  // Beat from the era split to the civil date stages
  typedef struct packed {
    logic [15:0]      era;  // low 16 bits of the era number
    logic [DOE_W-1:0] doe;
    tod_t             tod;
  } era_beat_t;

  // Finished result beat
  typedef struct packed {
    tod_t        tod;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [15:0] year;
    logic [2:0]  wday;
  } cal_beat_t;

  // Days from March 1 to the first of a March-based month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    unique case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/core/ecal_day_split.sv @@
// Floor split of signed seconds into whole days and second of day (4 stages)
module ecal_day_split #(
  parameter int SECONDS_WIDTH = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [SECONDS_WIDTH-1:0]       in_seconds,
  output logic                           out_valid,
  output logic signed [SECONDS_WIDTH-17:0] out_days,
  output logic [ecal_pkg::SOD_W-1:0]     out_sod
);
  import ecal_pkg::*;

  localparam int MAG_W  = SECONDS_WIDTH - 1;   // magnitude after folding the sign
  localparam int HI_W   = SECONDS_WIDTH - 20;  // upper digit of seconds / 128
  localparam int Q1_W   = HI_W - 9;            // upper digit of the day count
  localparam int DAYS_W = SECONDS_WIDTH - 16;
  localparam logic [HI_W:0] RCP_HI =
    (HI_W+1)'(((64'd1 << (HI_W + 10)) + 64'd674) / 64'd675);

  // Negative input: divide ~s, then quotient is ~q and remainder 86399 - r
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [2*HI_W:0]   hi_prod;

  assign neg     = in_seconds[SECONDS_WIDTH-1];
  assign mag     = neg ? ~in_seconds[MAG_W-1:0] : in_seconds[MAG_W-1:0];
  assign hi_prod = (2*HI_W+1)'(mag[MAG_W-1:19]) * (2*HI_W+1)'(RCP_HI);

  // Stage 1: upper digit quotient
  logic             v1_r, neg1_r;
  logic [HI_W-1:0]  hi1_r;
  logic [11:0]      lo1_r;
  logic [DAY_LO_SHIFT-1:0] fr1_r;
  logic [Q1_W-1:0]  q1_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    neg1_r <= neg;
    hi1_r  <= mag[MAG_W-1:19];
    lo1_r  <= mag[18:7];
    fr1_r  <= mag[DAY_LO_SHIFT-1:0];
    q1_1_r <= hi_prod[2*HI_W:HI_W+10];
  end

  // Stage 2: upper digit remainder joins the lower digit
  logic [HI_W-1:0] r1;
  logic            v2_r, neg2_r;
  logic [21:0]     t2_r;
  logic [DAY_LO_SHIFT-1:0] fr2_r;
  logic [Q1_W-1:0] q1_2_r;

  assign r1 = HI_W'(hi1_r - HI_W'(q1_1_r) * HI_W'(DAY_ODD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    neg2_r <= neg1_r;
    t2_r   <= {r1[9:0], lo1_r};
    fr2_r  <= fr1_r;
    q1_2_r <= q1_1_r;
  end

  // Stage 3: lower digit quotient
  logic [44:0] t_prod;
  logic        v3_r, neg3_r;
  logic [21:0] t3_r;
  logic [DAY_LO_SHIFT-1:0] fr3_r;
  logic [Q1_W-1:0] q1_3_r;
  logic [11:0] q2_3_r;

  assign t_prod = 45'(t2_r) * 45'(RCP_T675);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    neg3_r <= neg2_r;
    t3_r   <= t2_r;
    fr3_r  <= fr2_r;
    q1_3_r <= q1_2_r;
    q2_3_r <= t_prod[43:32];
  end

  // Stage 4: lower remainder, sign restore
  logic [21:0]       r2;
  logic [DAYS_W-1:0] days_mag;
  logic [SOD_W-1:0]  sod_mag;
  logic              v4_r;
  logic [DAYS_W-1:0] days4_r;
  logic [SOD_W-1:0]  sod4_r;

  assign r2       = 22'(t3_r - 22'(q2_3_r) * 22'(DAY_ODD));
  assign days_mag = {1'b0, q1_3_r, q2_3_r};
  assign sod_mag  = {r2[9:0], fr3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    days4_r <= neg3_r ? ~days_mag : days_mag;
    sod4_r  <= neg3_r ? SOD_W'(DAY_LAST_SEC - sod_mag) : sod_mag;
  end

  assign out_valid = v4_r;
  assign out_days  = days4_r;
  assign out_sod   = sod4_r;

  // A wrong reciprocal shows up as a second of day past the end of the day
  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sod <= DAY_LAST_SEC))
    else $error("ecal_day_split: second of day out of range");

endmodule

@@ rtl/core/ecal_era_split.sv @@
// Day count to era and day of era, second of day to h:m:s (3 stages)
module ecal_era_split #(
  parameter int SECONDS_WIDTH = 40
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [SECONDS_WIDTH-17:0] in_days,
  input  logic [ecal_pkg::SOD_W-1:0]       in_sod,
  output logic                             out_valid,
  output ecal_pkg::era_beat_t              out_beat
);
  import ecal_pkg::*;

  localparam int Z_W  = (SECONDS_WIDTH - 15 > 22) ? SECONDS_WIDTH - 15 : 22;
  localparam int ZA_W = Z_W - 1;
  localparam int QE_W = ZA_W - 17;
  localparam logic [ZA_W:0] RCP_ERA =
    (ZA_W+1)'(((64'd1 << (ZA_W + 18)) + 64'd146096) / 64'd146097);

  // Shift day 0 to 0000-03-01 and fold the sign
  logic signed [Z_W-1:0] z;
  logic                  zneg;
  logic [ZA_W-1:0]       za;
  logic [34:0]           mt_prod;

  assign z       = Z_W'(in_days) + Z_W'(MARCH_SHIFT);
  assign zneg    = z[Z_W-1];
  assign za      = zneg ? ~z[ZA_W-1:0] : z[ZA_W-1:0];
  assign mt_prod = 35'(in_sod) * 35'(RCP_SOD60);

  // Stage 1: folded day count, minute of day
  logic            v1_r, zneg1_r;
  logic [ZA_W-1:0] za1_r;
  logic [SOD_W-1:0] sod1_r;
  logic [10:0]     mt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    zneg1_r <= zneg;
    za1_r   <= za;
    sod1_r  <= in_sod;
    mt1_r   <= mt_prod[33:23];
  end

  // Stage 2: era quotient, second and hour
  logic [2*ZA_W:0] era_prod;
  logic [SOD_W-1:0] sec_full;
  logic [22:0]     hr_prod;
  logic            v2_r, zneg2_r;
  logic [ZA_W-1:0] za2_r;
  logic [QE_W-1:0] qe2_r;
  logic [10:0]     mt2_r;
  logic [5:0]      sec2_r;
  logic [4:0]      hr2_r;

  assign era_prod = (2*ZA_W+1)'(za1_r) * (2*ZA_W+1)'(RCP_ERA);
  assign sec_full = SOD_W'(sod1_r - SOD_W'(mt1_r) * SOD_W'(UNIT_60));
  assign hr_prod  = 23'(mt1_r) * 23'(RCP_MIN60);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    zneg2_r <= zneg1_r;
    za2_r   <= za1_r;
    qe2_r   <= era_prod[2*ZA_W:ZA_W+18];
    mt2_r   <= mt1_r;
    sec2_r  <= sec_full[5:0];
    hr2_r   <= hr_prod[21:17];
  end

  // Stage 3: day of era, sign restore, minute
  logic [ZA_W-1:0] rz;
  logic [15:0]     qe16;
  logic [10:0]     min_full;
  logic            v3_r;
  era_beat_t       beat3_r;

  assign rz       = ZA_W'(za2_r - ZA_W'(qe2_r) * ZA_W'(ERA_DAYS));
  assign qe16     = 16'(qe2_r);
  assign min_full = 11'(mt2_r - 11'(hr2_r) * 11'(UNIT_60));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    beat3_r.era        <= zneg2_r ? ~qe16 : qe16;
    beat3_r.doe        <= zneg2_r ? DOE_W'(ERA_LAST_DOE - rz[DOE_W-1:0]) : rz[DOE_W-1:0];
    beat3_r.tod.sec    <= sec2_r;
    beat3_r.tod.minute <= min_full[5:0];
    beat3_r.tod.hour   <= hr2_r;
  end

  assign out_valid = v3_r;
  assign out_beat  = beat3_r;

  // Day of era must stay inside one 400-year cycle
  a_doe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.doe <= ERA_LAST_DOE))
    else $error("ecal_era_split: day of era out of range");

endmodule

@@ rtl/core/ecal_civil.sv @@
// Day of era to year, month, day and weekday (7 stages)
module ecal_civil (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ecal_pkg::era_beat_t in_beat,
  output logic                out_valid,
  output ecal_pkg::cal_beat_t out_beat
);
  import ecal_pkg::*;

  // Stage 1: leap corrections and week quotient
  logic [DOE_W-1:0] dw;
  logic [36:0]      p1460, p36524, p7;
  logic             v1_r;
  era_beat_t        b1_r;
  logic [6:0]       q1460_1_r;
  logic [2:0]       q36524_1_r;
  logic [14:0]      qw1_r;

  assign dw     = DOE_W'(in_beat.doe + DOE_W'(WDAY_SHIFT));
  assign p1460  = 37'(in_beat.doe) * 37'(RCP_1460);
  assign p36524 = 37'(in_beat.doe) * 37'(RCP_36524);
  assign p7     = 37'(dw) * 37'(RCP_WEEK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    b1_r       <= in_beat;
    q1460_1_r  <= p1460[35:29];
    q36524_1_r <= p36524[36:34];
    qw1_r      <= p7[35:21];
  end

  // Stage 2: leap-free day count, weekday
  logic [DOE_W-1:0] x;
  logic [DOE_W-1:0] wd_full;
  logic             v2_r;
  era_beat_t        b2_r;
  logic [DOE_W-1:0] x2_r;
  logic [2:0]       wd2_r;

  assign x = DOE_W'(b1_r.doe - DOE_W'(q1460_1_r) + DOE_W'(q36524_1_r)
             - DOE_W'(b1_r.doe == ERA_LAST_DOE));
  assign wd_full = DOE_W'(DOE_W'(b1_r.doe + DOE_W'(WDAY_SHIFT))
                   - DOE_W'(qw1_r) * DOE_W'(WEEK_DAYS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    b2_r  <= b1_r;
    x2_r  <= x;
    wd2_r <= wd_full[2:0];
  end

  // Stage 3: year of era
  logic [36:0] py;
  logic        v3_r;
  era_beat_t   b3_r;
  logic [8:0]  yoe3_r;
  logic [2:0]  wd3_r;

  assign py = 37'(x2_r) * 37'(RCP_365);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    b3_r   <= b2_r;
    yoe3_r <= py[35:27];
    wd3_r  <= wd2_r;
  end

  // Stage 4: days before this year of era, base year
  logic [18:0]      p100;
  logic [DOE_W-1:0] k;
  logic [15:0]      ybase;
  logic             v4_r;
  logic [DOE_W-1:0] doe4_r;
  tod_t             tod4_r;
  logic [DOE_W-1:0] k4_r;
  logic [1:0]       y100_4_r;
  logic [15:0]      ybase4_r;
  logic [2:0]       wd4_r;

  assign p100  = 19'(yoe3_r) * 19'(RCP_100);
  assign k     = DOE_W'(DOE_W'(yoe3_r) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe3_r[8:2]));
  assign ybase = 16'(16'(yoe3_r) + b3_r.era * 16'(ERA_YEARS) - 16'(YEAR_BASE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    doe4_r   <= b3_r.doe;
    tod4_r   <= b3_r.tod;
    k4_r     <= k;
    y100_4_r <= p100[17:16];
    ybase4_r <= ybase;
    wd4_r    <= wd3_r;
  end

  // Stage 5: day of March-based year
  logic [DOE_W-1:0] doy_full;
  logic             v5_r;
  tod_t             tod5_r;
  logic [8:0]       doy5_r;
  logic [15:0]      ybase5_r;
  logic [2:0]       wd5_r;

  assign doy_full = DOE_W'(doe4_r - DOE_W'(k4_r - DOE_W'(y100_4_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    tod5_r   <= tod4_r;
    doy5_r   <= doy_full[8:0];
    ybase5_r <= ybase4_r;
    wd5_r    <= wd4_r;
  end

  // Stage 6: March-based month
  logic [10:0] v153;
  logic [22:0] p153;
  logic        v6_r;
  tod_t        tod6_r;
  logic [8:0]  doy6_r;
  logic [3:0]  mp6_r;
  logic [15:0] ybase6_r;
  logic [2:0]  wd6_r;

  assign v153 = 11'(11'(doy5_r) * 11'd5 + 11'd2);
  assign p153 = 23'(v153) * 23'(RCP_153);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    tod6_r   <= tod5_r;
    doy6_r   <= doy5_r;
    mp6_r    <= p153[22:19];
    ybase6_r <= ybase5_r;
    wd6_r    <= wd5_r;
  end

  // Stage 7: day of month, January-based month, year carry
  logic [8:0] mday_full;
  logic       past_dec;
  logic       v7_r;
  cal_beat_t  out7_r;

  assign mday_full = 9'(doy6_r - month_offset(mp6_r) + 9'd1);
  assign past_dec  = (mp6_r >= MP_JAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    out7_r.tod   <= tod6_r;
    out7_r.mday  <= mday_full[4:0];
    out7_r.month <= past_dec ? 4'(mp6_r - MP_JAN) : 4'(mp6_r + 4'd2);
    out7_r.year  <= 16'(ybase6_r + 16'(past_dec));
    out7_r.wday  <= wd6_r;
  end

  assign out_valid = v7_r;
  assign out_beat  = out7_r;

endmodule

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// Top level of the epoch seconds to UTC calendar converter
// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into UTC
// second, minute, hour, day of month, month (0 is January), year minus 1900 and
// weekday (0 is Sunday) in the proleptic Gregorian calendar; negative counts
// fall on the correct earlier day. A timestamp is taken at every clock edge
// where start is high (busy is always low), and its result appears on the
// out_ ports with out_strobe high for one cycle, in order, after passing
// through the pipeline stages: 4 split seconds into days, 3 split days into
// 400-year eras alongside hour/minute/second, and 7 derive year, month, day
// and weekday. Results cannot be held off, so the receiver must take each
// strobe as it comes.
module epoch_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                            out_strobe,
  output logic [5:0]                      out_second_of_minute,
  output logic [5:0]                      out_minute_of_hour,
  output logic [4:0]                      out_hour_of_day,
  output logic [4:0]                      out_day_of_month,
  output logic [3:0]                      out_month_index,
  output logic signed [15:0]              out_year_since_1900,
  output logic [2:0]                      out_weekday
);
  import ecal_pkg::*;

  logic                             accept;
  logic                             days_valid;
  logic signed [SECONDS_WIDTH-17:0] days;
  logic [SOD_W-1:0]                 sod;
  logic                             era_valid;
  era_beat_t                        era_beat;
  logic                             cal_valid;
  cal_beat_t                        cal_beat;

  // Fully pipelined: a beat can enter every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ecal_day_split #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_day_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_seconds (in_epoch_seconds),
    .out_valid  (days_valid),
    .out_days   (days),
    .out_sod    (sod)
  );

  ecal_era_split #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_era_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (days_valid),
    .in_days   (days),
    .in_sod    (sod),
    .out_valid (era_valid),
    .out_beat  (era_beat)
  );

  ecal_civil u_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (era_valid),
    .in_beat   (era_beat),
    .out_valid (cal_valid),
    .out_beat  (cal_beat)
  );

  // Result ports straight from the last pipeline register
  assign out_strobe           = cal_valid;
  assign out_second_of_minute = cal_beat.tod.sec;
  assign out_minute_of_hour   = cal_beat.tod.minute;
  assign out_hour_of_day      = cal_beat.tod.hour;
  assign out_day_of_month     = cal_beat.mday;
  assign out_month_index      = cal_beat.month;
  assign out_year_since_1900  = cal_beat.year;
  assign out_weekday          = cal_beat.wday;

  // Every result beat traces back to a start exactly one pipeline depth earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_LATENCY))
    else $error("epoch_seconds_to_calendar: strobe without matching start");

  // Calendar fields of a result beat stay legal together
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_month_index <= 4'd11) && (out_day_of_month != 5'd0)
                   && (out_weekday <= 3'd6) && (out_hour_of_day <= 5'd23))
    else $error("epoch_seconds_to_calendar: result field out of range");

endmodule

@@ sim/calendar_check_pkg.sv @@
// Scoreboard and civil-date predictor for the epoch seconds to calendar testbench
`timescale 1ns / 1ps
package calendar_check_pkg;

  localparam int EPOCH_W = 40;

  // Broken-down UTC time as the block reports it
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [15:0] year;
    logic [2:0]  wday;
  } civil_time_t;

  // One predicted date, kept with the timestamp that produced it
  typedef struct {
    longint      secs;
    civil_time_t fields;
  } pending_date_t;

  class civil_time_scoreboard;
    pending_date_t dates_due[$];
    int errors;
    int checked;
    int noted;
    int printed;

    function new();
      errors  = 0;
      checked = 0;
      noted   = 0;
      printed = 0;
    endfunction

    // Floor-divide seconds into days, then days into eras for the date
    function civil_time_t predict_civil(input logic signed [EPOCH_W-1:0] raw);
      longint secs, days, rem, z, era, doe, yoe, doy, mp, mday, mon, year, wday;
      civil_time_t t;
      secs = longint'(raw);
      days = secs / 86400;
      rem  = secs % 86400;
      if (rem < 0) begin
        rem  += 86400;
        days -= 1;
      end
      t.sec    = 6'(rem % 60);
      t.minute = 6'((rem / 60) % 60);
      t.hour   = 5'(rem / 3600);
      // day 0 of the shifted count is 0000-03-01
      z    = days + 719468;
      era  = (z >= 0 ? z : z - 146096) / 146097;
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mday = doy - (153 * mp + 2) / 5 + 1;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) year += 1;
      // 1970-01-01 was a Thursday
      wday = ((days % 7) + 7 + 4) % 7;
      t.mday  = 5'(mday);
      t.month = 4'(mon - 1);
      t.year  = 16'(year - 1900);
      t.wday  = 3'(wday);
      return t;
    endfunction

    function int pending();
      return dates_due.size();
    endfunction

    function void note_input(input logic signed [EPOCH_W-1:0] secs);
      pending_date_t p;
      p.secs   = longint'(secs);
      p.fields = predict_civil(secs);
      dates_due.push_back(p);
      noted++;
    endfunction

    task report(input string msg);
      errors++;
      if (printed < 40) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        printed++;
      end
    endtask

    task compare_field(input string name, input longint secs,
                       input logic signed [31:0] got, input logic signed [31:0] want);
      if (got !== want)
        report($sformatf("%0d s: %s is %0d, expected %0d", secs, name, got, want));
    endtask

    task check_result(input civil_time_t got);
      pending_date_t p;
      if (dates_due.size() == 0) begin
        report("result beat with no timestamp outstanding");
        return;
      end
      p = dates_due.pop_front();
      checked++;
      compare_field("second_of_minute", p.secs, 32'(got.sec), 32'(p.fields.sec));
      compare_field("minute_of_hour", p.secs, 32'(got.minute), 32'(p.fields.minute));
      compare_field("hour_of_day", p.secs, 32'(got.hour), 32'(p.fields.hour));
      compare_field("day_of_month", p.secs, 32'(got.mday), 32'(p.fields.mday));
      compare_field("month_index", p.secs, 32'(got.month), 32'(p.fields.month));
      compare_field("year_since_1900", p.secs, 32'($signed(got.year)),
                    32'($signed(p.fields.year)));
      compare_field("weekday", p.secs, 32'(got.wday), 32'(p.fields.wday));
    endtask

    task close_out();
      if (dates_due.size() != 0)
        report($sformatf("%0d result beats never arrived", dates_due.size()));
    endtask
  endclass

endpackage

@@ sim/tb_top.sv @@
// Top-level testbench for the epoch seconds to calendar converter
`timescale 1ns / 1ps
module tb_top;
  import ecal_pkg::*;
  import calendar_check_pkg::*;

  localparam int     N_RANDOM   = 1850;
  localparam int     QUIET_MAX  = 1000;
  localparam longint EPOCH_MAX  = (longint'(1) << (EPOCH_W - 1)) - 1;
  localparam longint EPOCH_MIN  = -(longint'(1) << (EPOCH_W - 1));
  localparam longint DAY_SECS   = 86400;
  localparam longint EPOCH_DAYS = 719468;  // days from 0000-03-01 to 1970-01-01
  localparam longint ERA_SPAN   = 146097;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [EPOCH_W-1:0] in_epoch_seconds = '0;
  logic                      out_strobe;
  logic [5:0]                out_second_of_minute;
  logic [5:0]                out_minute_of_hour;
  logic [4:0]                out_hour_of_day;
  logic [4:0]                out_day_of_month;
  logic [3:0]                out_month_index;
  logic signed [15:0]        out_year_since_1900;
  logic [2:0]                out_weekday;

  civil_time_scoreboard sb;
  longint last_sent = 0;
  int     quiet_cycles = 0;

  epoch_seconds_to_calendar #(
    .SECONDS_WIDTH(EPOCH_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_epoch_seconds    (in_epoch_seconds),
    .out_strobe          (out_strobe),
    .out_second_of_minute(out_second_of_minute),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_hour_of_day     (out_hour_of_day),
    .out_day_of_month    (out_day_of_month),
    .out_month_index     (out_month_index),
    .out_year_since_1900 (out_year_since_1900),
    .out_weekday         (out_weekday)
  );

  always #5 clk = ~clk;

  // Monitor: note accepted timestamps, check result beats, watch for a hang
  always @(posedge clk) begin : monitor
    civil_time_t got;
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_epoch_seconds);
      if (out_strobe) begin
        got.sec    = out_second_of_minute;
        got.minute = out_minute_of_hour;
        got.hour   = out_hour_of_day;
        got.mday   = out_day_of_month;
        got.month  = out_month_index;
        got.year   = out_year_since_1900;
        got.wday   = out_weekday;
        sb.check_result(got);
      end
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Timeout: %0d cycles without a beat, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one timestamp and hold it until the block takes it
  task automatic send_beat(input longint secs);
    start            <= 1'b1;
    in_epoch_seconds <= EPOCH_W'(secs);
    last_sent         = secs;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and put junk on the data port for a gap of the given length
  task automatic hold_off(input int n);
    if (n > 0) begin
      start            <= 1'b0;
      in_epoch_seconds <= EPOCH_W'({$urandom(), $urandom()});
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a timestamp: full range, near the epoch, on day edges, on era edges,
  // at the range limits, or a short walk forward from the last one
  function automatic longint pick_seconds();
    longint days, z, doe;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return longint'($signed(EPOCH_W'({$urandom(), $urandom()})));
      4, 5: return longint'(int'($urandom()));
      6: begin
        days = longint'($urandom_range(0, 12_000_000)) - 6_000_000;
        case ($urandom_range(0, 3))
          0: return days * DAY_SECS;
          1: return days * DAY_SECS - 1;
          2: return days * DAY_SECS + DAY_SECS - 1;
          default: return days * DAY_SECS + 1;
        endcase
      end
      7: begin
        // leap days, century years and era ends, counted from March 1
        case ($urandom_range(0, 13))
          0: doe = 0;
          1: doe = 59;
          2: doe = 60;
          3: doe = 305;
          4: doe = 306;
          5: doe = 365;
          6: doe = 1460;
          7: doe = 1461;
          8: doe = 36523;
          9: doe = 36524;
          10: doe = 36525;
          11: doe = 146095;
          12: doe = 146096;
          default: doe = $urandom_range(0, 146096);
        endcase
        z    = (longint'($urandom_range(0, 76)) - 36) * ERA_SPAN + doe;
        days = z - EPOCH_DAYS;
        return days * DAY_SECS + $urandom_range(0, 86399);
      end
      8: begin
        if ($urandom_range(0, 1)) return EPOCH_MAX - $urandom_range(0, 200000);
        return EPOCH_MIN + $urandom_range(0, 200000);
      end
      default: return longint'($signed(EPOCH_W'(last_sent + $urandom_range(1, 90000))));
    endcase
  endfunction

  initial begin : stimulus
    longint directed[] = '{
      0, -1, 1, 59, 60, 3599, 3600, 86399, 86400, -86400, -86401,
      EPOCH_MAX, EPOCH_MIN,
      951782400,                             // leap day of a leap century
      951868800,                             // the following March 1
      -64'sd2203891200,                      // March 1 of a non-leap century
      -64'sd2208988800,                      // first day of 1900
      -64'sd62135596800,                     // first day of year 1
      -EPOCH_DAYS * DAY_SECS,                // start of an era
      -EPOCH_DAYS * DAY_SECS - 1,            // last second of the era before
      64'sd253402300799, 64'sd253402300800,  // around the end of year 9999
      2147483647, -64'sd2147483648
    };
    bit burst;
    sb = new();
    burst = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edge cases
    foreach (directed[i]) begin
      send_beat(directed[i]);
      hold_off(gap_len());
    end
    drain();

    // Random timestamps, with idle-free stretches and periodic full drains
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      send_beat(pick_seconds());
      if (i % 450 == 449) drain();
      else hold_off(burst ? 0 : gap_len());
    end
    drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    sb.close_out();

    $display("Converted %0d timestamps (%0d directed) and checked %0d dates,",
             sb.noted, directed.size(), sb.checked);
    $display("spanning the full 40-bit range, day and era edges, and leap days.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
